FILE: sv/pmlp_pkg.sv
// Shared types, constants and page-map helpers of the page map layout planner.
package pmlp_pkg;

   localparam logic [7:0] FULL_DRIVER_PAGES = 8'd4;
   localparam logic [7:0] MIN_DRIVER_PAGES  = 8'd2;
   localparam logic [7:0] SCREEN_PAGES      = 8'd4;
   localparam logic [7:0] CHARSET_PAGES     = 8'd8;

   localparam logic [7:0] LOW_RSV_LAST  = 8'h03;
   localparam logic [7:0] IO_RSV_FIRST  = 8'ha0;
   localparam logic [7:0] IO_RSV_LAST   = 8'hbf;
   localparam logic [7:0] TOP_RSV_FIRST = 8'hd0;
   localparam logic [7:0] LAST_PAGE     = 8'hff;
   localparam logic [5:0] SCR_SKIP_LO   = 6'h10;
   localparam logic [5:0] SCR_SKIP_HI   = 6'h20;

   typedef struct packed {
      logic [7:0]  window_start_page;
      logic [7:0]  window_page_count;
      logic [15:0] image_load_address;
      logic [16:0] image_length;
      logic [7:0]  text_pages;
   } req_type;

   typedef struct packed {
      logic [7:0] driver_start;
      logic [7:0] screen_start;
      logic [7:0] charset_start;
      logic [7:0] text_start;
   } rsp_type;

   // Compact description of the occupancy map: each page is decoded on demand.
   typedef struct packed {
      logic       derived;
      logic       img_valid;
      logic [7:0] img_lo;
      logic [7:0] img_hi;
      logic [7:0] win_lo;
      logic [8:0] win_end;
   } map_desc_type;

   typedef struct packed {
      logic [7:0] size;
      logic [7:0] scr;
      logic [7:0] chr;
      logic [7:0] drv;
   } fit_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] page;
   } fit_rsp_type;

   function automatic logic reserved_page(input logic [7:0] p);
      return (p <= LOW_RSV_LAST) || ((p >= IO_RSV_FIRST) && (p <= IO_RSV_LAST))
         || (p >= TOP_RSV_FIRST);
   endfunction

   function automatic logic page_busy(input map_desc_type d, input logic [7:0] p);
      logic img;
      img = d.img_valid && (p >= d.img_lo) && (p <= d.img_hi);
      if (d.derived) begin
         return reserved_page(p) || img;
      end else begin
         return !((p >= d.win_lo) && ({1'b0, p} < d.win_end));
      end
   endfunction

   function automatic logic in_span(input logic [7:0] p, input logic [7:0] base,
                                    input logic [7:0] len);
      return (base != 8'd0) && (p >= base) && ({1'b0, p} < ({1'b0, base} + {1'b0, len}));
   endfunction

endpackage

FILE: sv/pmlp_fit_scan.sv
// First-fit run search over the page map, one page per cycle.
module pmlp_fit_scan
   import pmlp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  fit_req_type  fit_req,
   input  map_desc_type desc,
   output fit_rsp_type  fit_rsp
);

   logic        active_ff, active_in;
   logic [7:0]  page_ff, page_in;
   logic [8:0]  first_ff, first_in;
   fit_req_type req_ff, req_in;
   fit_rsp_type rsp_ff, rsp_in;
   logic        busy_pg;

   always_comb begin
      busy_pg = page_busy(desc, page_ff) || in_span(page_ff, req_ff.scr, SCREEN_PAGES)
         || in_span(page_ff, req_ff.chr, CHARSET_PAGES)
         || in_span(page_ff, req_ff.drv, FULL_DRIVER_PAGES);
      active_in = active_ff;
      page_in   = page_ff;
      first_in  = first_ff;
      req_in    = req_ff;
      rsp_in    = '{done: 1'b0, page: rsp_ff.page};
      if (go) begin
         active_in = 1'b1;
         page_in   = 8'd0;
         first_in  = 9'd0;
         req_in    = fit_req;
      end else if (active_ff) begin
         page_in = page_ff + 8'd1;
         // a run counts only when a busy page closes it
         if (busy_pg && (({1'b0, page_ff} - first_ff) >= {1'b0, req_ff.size})) begin
            active_in = 1'b0;
            rsp_in    = '{done: 1'b1, page: first_ff[7:0]};
         end else begin
            if (busy_pg) begin
               first_in = {1'b0, page_ff} + 9'd1;
            end
            if (page_ff == LAST_PAGE) begin
               active_in = 1'b0;
               rsp_in    = '{done: 1'b1, page: 8'd0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         rsp_ff.done <= 1'b0;
      end else begin
         active_ff   <= active_in;
         rsp_ff.done <= rsp_in.done;
      end
      page_ff      <= page_in;
      first_ff     <= first_in;
      req_ff       <= req_in;
      rsp_ff.page  <= rsp_in.page;
   end

   assign fit_rsp = rsp_ff;

endmodule

FILE: sv/page_map_layout_planner_core.sv
// Top level: request decode, slot sequencer and result register of the layout planner.
//
//   channel   ports                        handshake
//   request   start, busy, req_data        word taken when start && !busy
//   result    rsp_valid, rsp_data          one-cycle strobe, cannot be held off
//
// Each request is decoded, then each screen or charset candidate is checked in
// turn, and each candidate that passes starts a first-fit scan of the shared search
// unit (it stops at the first run that fits). Worst case is 288 candidates with 248
// failed driver scans plus a final scan; an invalid or empty window is answered
// from the idle state without a scan.
// The page map is decoded from the request, so no clearing pass follows reset.
// busy stays high from acceptance until the result strobe; an invalid or empty window never raises it.
module page_map_layout_planner_core
   import pmlp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CAND, ST_FULL, ST_TEXT, ST_MIN
   } state_type;

   state_type    state_ff, state_in;
   logic [1:0]   b_ff, b_in;
   logic [3:0]   j_ff, j_in;
   logic [2:0]   k_ff, k_in;
   logic [7:0]   text_ff, text_in;
   map_desc_type desc_ff, desc_in;
   rsp_type      res_ff, res_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic         fit_go;
   fit_req_type  fit_req;
   fit_rsp_type  fit_rsp;

   logic [1:0]   bank_code;
   logic         char_bank;
   logic [7:0]   scr_page, chr_page;
   logic         scr_free, chr_free, skip_cand;
   logic [1:0]   nb;
   logic [3:0]   nj;
   logic [2:0]   nk;
   logic         exhausted;
   logic [17:0]  img_end;
   logic [8:0]   win_end;
   logic [7:0]   win_last;
   logic         win_ok;

   pmlp_fit_scan u_fit (
      .clock  (clock),
      .reset  (reset),
      .go     (fit_go),
      .fit_req(fit_req),
      .desc   (desc_ff),
      .fit_rsp(fit_rsp)
   );

   // bank order 0x00, 0x80, 0x40, 0xc0
   always_comb begin
      unique case (b_ff)
         2'd0: bank_code = 2'd0;
         2'd1: bank_code = 2'd2;
         2'd2: bank_code = 2'd1;
         default: bank_code = 2'd3;
      endcase
      char_bank = bank_code[0];
      scr_page  = {bank_code, j_ff, 2'b00};
      chr_page  = {bank_code, k_ff, 3'b000};
      scr_free  = 1'b1;
      chr_free  = 1'b1;
      for (int n = 0; n < 8; n++) begin
         if (n < 4 && page_busy(desc_ff, scr_page + 8'(n))) begin
            scr_free = 1'b0;
         end
         if (page_busy(desc_ff, chr_page + 8'(n))) begin
            chr_free = 1'b0;
         end
      end
      if (char_bank) begin
         skip_cand = !scr_free || !chr_free || (k_ff == j_ff[3:1]);
      end else begin
         skip_cand = !scr_free || (({j_ff, 2'b00} >= SCR_SKIP_LO)
            && ({j_ff, 2'b00} < SCR_SKIP_HI));
      end
      // next candidate: charset index first in charset banks
      nb = b_ff;
      nj = j_ff;
      nk = 3'd0;
      exhausted = 1'b0;
      if (char_bank && (k_ff != 3'd7)) begin
         nk = k_ff + 3'd1;
      end else if (j_ff != 4'd15) begin
         nj = j_ff + 4'd1;
      end else begin
         nj = 4'd0;
         nb = b_ff + 2'd1;
         exhausted = (b_ff == 2'd3);
      end
   end

   // request decode
   always_comb begin
      img_end  = {2'b00, req_data.image_load_address} + {1'b0, req_data.image_length}
         - 18'd1;
      win_end  = {1'b0, req_data.window_start_page} + {1'b0, req_data.window_page_count};
      if (win_end > 9'd256) begin
         win_end = 9'd256;
      end
      win_last = 8'(win_end - 9'd1);
      win_ok   = (req_data.window_start_page != LAST_PAGE)
         && (req_data.window_page_count != 8'd0)
         && !reserved_page(req_data.window_start_page) && !reserved_page(win_last);
   end

   always_comb begin
      state_in     = state_ff;
      b_in         = b_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      text_in      = text_ff;
      desc_in      = desc_ff;
      res_in       = res_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      fit_go       = 1'b0;
      fit_req      = '{size: FULL_DRIVER_PAGES, scr: scr_page,
                       chr: (char_bank ? chr_page : 8'd0), drv: 8'd0};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               desc_in.derived   = (req_data.window_start_page == 8'd0);
               desc_in.img_valid = (req_data.image_length != 17'd0);
               desc_in.img_lo    = req_data.image_load_address[15:8];
               desc_in.img_hi    = (img_end[17:16] != 2'b00) ? LAST_PAGE : img_end[15:8];
               desc_in.win_lo    = req_data.window_start_page;
               desc_in.win_end   = win_end;
               text_in = req_data.text_pages;
               b_in    = 2'd0;
               j_in    = 4'd0;
               k_in    = 3'd0;
               res_in  = '0;
               if (desc_in.derived || win_ok) begin
                  state_in = ST_CAND;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end
            end
         end
         ST_CAND: begin
            if (skip_cand) begin
               b_in = nb;
               j_in = nj;
               k_in = nk;
               if (exhausted) begin
                  fit_go   = 1'b1;
                  fit_req  = '{size: MIN_DRIVER_PAGES, scr: 8'd0, chr: 8'd0, drv: 8'd0};
                  state_in = ST_MIN;
               end
            end else begin
               fit_go   = 1'b1;
               state_in = ST_FULL;
            end
         end
         ST_FULL: begin
            if (fit_rsp.done) begin
               if (fit_rsp.page != 8'd0) begin
                  res_in.driver_start  = fit_rsp.page;
                  res_in.screen_start  = scr_page;
                  res_in.charset_start = char_bank ? chr_page : 8'd0;
                  if (text_ff != 8'd0) begin
                     fit_go   = 1'b1;
                     fit_req  = '{size: text_ff, scr: scr_page,
                                  chr: (char_bank ? chr_page : 8'd0), drv: fit_rsp.page};
                     state_in = ST_TEXT;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = res_in;
                     state_in     = ST_IDLE;
                  end
               end else begin
                  b_in = nb;
                  j_in = nj;
                  k_in = nk;
                  if (exhausted) begin
                     fit_go   = 1'b1;
                     fit_req  = '{size: MIN_DRIVER_PAGES, scr: 8'd0, chr: 8'd0, drv: 8'd0};
                     state_in = ST_MIN;
                  end else begin
                     state_in = ST_CAND;
                  end
               end
            end
         end
         ST_TEXT: begin
            if (fit_rsp.done) begin
               rsp_valid_in      = 1'b1;
               rsp_in            = res_ff;
               rsp_in.text_start = fit_rsp.page;
               state_in          = ST_IDLE;
            end
         end
         ST_MIN: begin
            if (fit_rsp.done) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.driver_start = fit_rsp.page;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b_ff    <= b_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      text_ff <= text_in;
      desc_ff <= desc_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: tb/page_map_layout_planner_core_test.sv
// Self-checking testbench for the page map layout planner core.
module page_map_layout_planner_core_test
   import pmlp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // allow for every word taking as long as the worst request several times over
   localparam int CYCLE_LIMIT  = 40_000_000;
   localparam int SETTLE       = 64;
   localparam int RANDOM_WORDS = 100;
   localparam int PHASE_WORDS  = 16;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   req_type pending_words[$];
   rsp_type planned_layouts[$];
   int      n_total = 0;
   int      n_taken = 0;
   int      n_answered = 0;
   int      mismatches = 0;
   int      cycles = 0;

   page_map_layout_planner_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit page_reserved(input int p);
      return p <= LOW_RSV_LAST || (p >= IO_RSV_FIRST && p <= IO_RSV_LAST) || p >= TOP_RSV_FIRST;
   endfunction

   function automatic bit covers(input int p, input int base, input int len);
      return base != 0 && p >= base && p < base + len;
   endfunction

   function automatic bit span_open(input logic [255:0] pmap, input int base, input int len);
      for (int p = base; p < base + len; p++)
         if (p > 255 || pmap[p]) return 1'b0;
      return 1'b1;
   endfunction

   // first-fit: a run only counts once a busy page closes it, so a run up to page 255 never does
   function automatic logic [7:0] fit_run(input logic [255:0] pmap, input int scr, input int chr,
                                          input int drv, input int size);
      int first;
      bit hit;
      first = 0;
      for (int i = 0; i < 256; i++) begin
         hit = pmap[i] || covers(i, scr, SCREEN_PAGES) || covers(i, chr, CHARSET_PAGES)
            || covers(i, drv, FULL_DRIVER_PAGES);
         if (hit) begin
            if (i - first >= size) return first[7:0];
            first = i + 1;
         end
      end
      return 8'd0;
   endfunction

   function automatic rsp_type plan_layout(input req_type r);
      logic [255:0] pmap;
      rsp_type      res;
      int           first_pg, count, endp, hi, bank, scr, chr;
      logic [7:0]   drv;
      bit           found;
      res      = '0;
      pmap     = '0;
      first_pg = r.window_start_page;
      count    = r.window_page_count;
      if (first_pg == 0) begin
         for (int p = 0; p < 256; p++) pmap[p] = page_reserved(p);
         if (r.image_length != 0) begin
            hi = (int'(r.image_load_address) + int'(r.image_length) - 1) >> 8;
            if (hi > 255) hi = 255;
            for (int p = r.image_load_address >> 8; p <= hi; p++) pmap[p] = 1'b1;
         end
      end else if (first_pg != LAST_PAGE && count != 0) begin
         endp = first_pg + count;
         if (endp > 256) endp = 256;
         if (page_reserved(first_pg) || page_reserved(endp - 1)) return res;
         for (int p = 0; p < 256; p++) pmap[p] = !(p >= first_pg && p < endp);
      end else begin
         return res;
      end

      found = 1'b0;
      for (int b = 0; b < 4 && !found; b++) begin
         // banks tried as 0x00, 0x80, 0x40, 0xc0
         bank = ((((b & 1) ^ (b >> 1)) != 0) ? (b ^ 3) : b) << 6;
         for (int j = 0; j < 64 && !found; j += 4) begin
            scr = bank + j;
            if ((bank & 'h40) == 0 && j >= SCR_SKIP_LO && j < SCR_SKIP_HI) begin
               // screen cannot sit over the character ROM image
            end else if (span_open(pmap, scr, SCREEN_PAGES)) begin
               if ((bank & 'h40) != 0) begin
                  for (int k = 0; k < 64 && !found; k += 8) begin
                     chr = bank + k;
                     if (k != (j & 'h38) && span_open(pmap, chr, CHARSET_PAGES)) begin
                        drv = fit_run(pmap, scr, chr, 0, FULL_DRIVER_PAGES);
                        if (drv != 0) begin
                           found             = 1'b1;
                           res.driver_start  = drv;
                           res.screen_start  = scr[7:0];
                           res.charset_start = chr[7:0];
                        end
                     end
                  end
               end else begin
                  drv = fit_run(pmap, scr, 0, 0, FULL_DRIVER_PAGES);
                  if (drv != 0) begin
                     found            = 1'b1;
                     res.driver_start = drv;
                     res.screen_start = scr[7:0];
                  end
               end
            end
         end
      end

      if (!found)
         res.driver_start = fit_run(pmap, 0, 0, 0, MIN_DRIVER_PAGES);
      else if (r.text_pages != 0)
         res.text_start = fit_run(pmap, res.screen_start, res.charset_start, res.driver_start,
                                  r.text_pages);
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus

   task automatic queue_word(input logic [7:0] first_pg, input logic [7:0] count,
                             input logic [15:0] load, input logic [16:0] len,
                             input logic [7:0] text);
      req_type w;
      w.window_start_page  = first_pg;
      w.window_page_count  = count;
      w.image_load_address = load;
      w.image_length       = len;
      w.text_pages         = text;
      pending_words.push_back(w);
   endtask

   function automatic logic [7:0] random_text();
      return ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
   endfunction

   initial begin : stimulus
      int         kind, region, lo, last;
      logic [7:0] bad;
      // derived maps
      queue_word(8'h00, 8'h00, 16'h0801, 17'h01000, 8'd3);
      queue_word(8'h00, 8'hff, 16'h0000, 17'h00000, 8'd0);   // zero length image
      queue_word(8'h00, 8'h5a, 16'hffff, 17'h1ffff, 8'hff);  // image end saturates, text too big
      queue_word(8'h00, 8'h00, 16'hff00, 17'h00100, 8'd1);
      queue_word(8'h00, 8'h00, 16'h0400, 17'h09c00, 8'd2);   // only top bank left: charset needed
      queue_word(8'h00, 8'h00, 16'h0400, 17'h0c900, 8'd1);   // no screen slot, minimal driver
      queue_word(8'h00, 8'h00, 16'h0400, 17'h0cc00, 8'd1);   // no room at all
      queue_word(8'h00, 8'h00, 16'h0000, 17'h10000, 8'd4);
      // invalid and empty windows
      queue_word(8'h03, 8'd20, 16'hffff, 17'h1ffff, 8'd2);
      queue_word(8'ha0, 8'd4,  16'h1234, 17'h00010, 8'd2);
      queue_word(8'hbf, 8'd1,  16'h1234, 17'h00010, 8'd2);
      queue_word(8'hd0, 8'd8,  16'h1234, 17'h00010, 8'd2);
      queue_word(8'h90, 8'h20, 16'h1234, 17'h00010, 8'd2);   // last page in the I/O hole
      queue_word(8'hff, 8'd10, 16'h1234, 17'h00010, 8'd2);
      queue_word(8'h10, 8'd0,  16'h1234, 17'h00010, 8'd2);
      queue_word(8'h04, 8'hff, 16'h1234, 17'h00010, 8'd2);   // end clipped at page 255
      // valid windows
      queue_word(8'h04, 8'h9c, 16'h0000, 17'h00001, 8'd8);
      queue_word(8'h90, 8'h38, 16'h0000, 17'h00001, 8'd3);   // spans the I/O hole
      queue_word(8'hc0, 8'h10, 16'h0000, 17'h00001, 8'd1);
      queue_word(8'h10, 8'd5,  16'h0000, 17'h00001, 8'd1);
      queue_word(8'h44, 8'd12, 16'h0000, 17'h00001, 8'd1);
      queue_word(8'h04, 8'd1,  16'h0000, 17'h00001, 8'd1);
      queue_word(8'h9f, 8'd1,  16'h0000, 17'h00001, 8'd1);
      queue_word(8'h20, 8'h40, 16'h0000, 17'h00001, 8'd200);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         kind = $urandom_range(9);
         if (kind < 4) begin
            queue_word(8'h00, 8'($urandom), 16'($urandom),
                       ($urandom_range(3) == 0) ? 17'($urandom_range(131071))
                                                : 17'($urandom_range(16384, 1)),
                       random_text());
         end else if (kind < 8) begin
            region = $urandom_range(2);
            if (region == 0) begin
               lo   = $urandom_range(IO_RSV_FIRST - 1, LOW_RSV_LAST + 1);
               last = $urandom_range(IO_RSV_FIRST - 1, lo);
            end else if (region == 1) begin
               lo   = $urandom_range(TOP_RSV_FIRST - 1, IO_RSV_LAST + 1);
               last = $urandom_range(TOP_RSV_FIRST - 1, lo);
            end else begin
               lo   = $urandom_range(IO_RSV_FIRST - 1, LOW_RSV_LAST + 1);
               last = $urandom_range(TOP_RSV_FIRST - 1, IO_RSV_LAST + 1);
            end
            queue_word(lo[7:0], 8'(last - lo + 1), 16'($urandom), 17'($urandom), random_text());
         end else if (kind == 8) begin
            case ($urandom_range(2))
               0:       bad = 8'($urandom_range(LOW_RSV_LAST, 1));
               1:       bad = 8'($urandom_range(IO_RSV_LAST, IO_RSV_FIRST));
               default: bad = 8'($urandom_range(LAST_PAGE, TOP_RSV_FIRST));
            endcase
            queue_word(bad, 8'($urandom_range(255, 1)), 16'($urandom), 17'($urandom),
                       random_text());
         end else begin
            queue_word(8'($urandom), 8'($urandom), 16'($urandom), 17'($urandom), 8'($urandom));
         end
      end
      n_total = pending_words.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (n_answered != n_total) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (planned_layouts.size() != 0) begin
         $display("%0t: %0d layouts never answered", $time, planned_layouts.size());
         mismatches = mismatches + planned_layouts.size();
      end
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : drive_words
      int idle_pct;
      bit hold;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            planned_layouts.push_back(plan_layout(req_data));
            n_taken = n_taken + 1;
         end
         if (!start || !busy) begin
            case ((n_taken / PHASE_WORDS) % 4)
               1:       idle_pct = 73;
               3:       idle_pct = 18;
               default: idle_pct = 0;
            endcase
            // at each phase boundary hold off until every layout is back
            hold = pending_words.size() == 0 || $urandom_range(99) < idle_pct
               || (n_taken % PHASE_WORDS == 0 && n_answered != n_taken);
            if (hold) begin
               start <= 1'b0;
            end else begin
               req_data <= pending_words.pop_front();
               start    <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatches = mismatches + 1;
      end
   endtask

   always @(posedge clock) begin : check_layouts
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (planned_layouts.size() == 0) begin
            $display("%0t: unexpected result word, expected none got %h", $time, rsp_data);
            mismatches = mismatches + 1;
         end else begin
            want = planned_layouts.pop_front();
            check_field("driver_start",  want.driver_start,  rsp_data.driver_start);
            check_field("screen_start",  want.screen_start,  rsp_data.screen_start);
            check_field("charset_start", want.charset_start, rsp_data.charset_start);
            check_field("text_start",    want.text_start,    rsp_data.text_start);
         end
         n_answered <= n_answered + 1;
      end
   end

   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timed out after %0d cycles", $time, cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

endmodule
